@@ rtl/tgb_pkg.sv @@
// ----------------------------------------------------------------------------
// tgb_pkg: shared types and a constant for the tangent/bitangent block
// Payload structs of the vertex and result channels, fixed-point unit constant.
// ----------------------------------------------------------------------------
package tgb_pkg;

  localparam int unsigned UNIT_Q14 = 16384;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
  } vtx_item_t;

  typedef struct packed {
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic signed [15:0] bitangent_x;
    logic signed [15:0] bitangent_y;
    logic signed [15:0] bitangent_z;
    logic               degenerate;
    logic               last_of_triangle;
  } basis_item_t;

endpackage

@@ rtl/tgb_if.sv @@
// ----------------------------------------------------------------------------
// tgb_if: valid/ready channels of the tangent/bitangent block
// One interface for vertex requests, one for basis results.
// ----------------------------------------------------------------------------
interface tgb_vtx_if;
  import tgb_pkg::*;
  logic      valid;
  logic      ready;
  vtx_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tgb_basis_if;
  import tgb_pkg::*;
  logic        valid;
  logic        ready;
  basis_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/triangle_tangent_bitangent.sv @@
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent: per-triangle tangent space basis
// First two vertices are held; the third runs one shared multiplier,
// a bit-serial square root and a restoring divider, then emits three results.
// First and second vertex: held only, ready again the next cycle.
// Third vertex: determinant, then for each of both vectors components, shift,
//   sum of squares, a 32-step square root and three 15-step divides, then the first result.
// Zero determinant: the determinant check goes straight to the results.
// Then three results, one per cycle while out_ch.ready is high.
// Reset (rst_n low, synchronous): sequencer idle, vertex count cleared.
// ----------------------------------------------------------------------------
module triangle_tangent_bitangent (
  input  logic clk,
  input  logic rst_n,
  tgb_vtx_if.sink     in_ch,
  tgb_basis_if.source out_ch
);
  import tgb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DET, S_CHK, S_COMP, S_ABS, S_SHIFT, S_SQ, S_SQRT, S_DIVI, S_DIV,
    S_NEXTV, S_OUT
  } state_t;

  state_t state_r;
  logic [1:0] phase_r;
  logic [4:0] cnt_r;
  logic [1:0] csel_r;
  logic       vsel_r;
  logic       flip_r;
  logic       degen_r;

  logic signed [31:0] hp_r [6];
  logic signed [15:0] ht_r [4];
  logic signed [32:0] e1_r [3];
  logic signed [32:0] e2_r [3];
  logic signed [16:0] du1_r, dv1_r, du2_r, dv2_r;
  logic signed [65:0] acc_r;
  logic signed [51:0] comp_r [3];
  logic [50:0] mag_r [3];
  logic [2:0]  neg_r;
  logic [63:0] sqv_r, res_r, bit_r;
  logic [31:0] n_r;
  logic [44:0] num_r, den_r;
  logic [14:0] q_r;
  logic signed [15:0] tq_r [3];
  logic signed [15:0] bq_r [3];

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [30:0] mul_b;
  logic signed [64:0] prod;
  logic [1:0]  ci;
  logic [50:0] mx01, mx;
  logic [63:0] sq_sum;
  logic [14:0] q_nxt;
  logic [15:0] qv;
  logic signed [15:0] qs;

  assign ci = cnt_r[2:1];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_DET: begin
        if (cnt_r[0] == 1'b0) begin
          mul_a = 34'(du1_r);
          mul_b = 31'(dv2_r);
        end else begin
          mul_a = 34'(du2_r);
          mul_b = 31'(dv1_r);
        end
      end
      S_COMP: begin
        case ({vsel_r, cnt_r[0]})
          2'b00:   begin mul_a = 34'(e1_r[ci]); mul_b = 31'(dv2_r); end
          2'b01:   begin mul_a = 34'(e2_r[ci]); mul_b = 31'(dv1_r); end
          2'b10:   begin mul_a = 34'(e2_r[ci]); mul_b = 31'(du1_r); end
          default: begin mul_a = 34'(e1_r[ci]); mul_b = 31'(du2_r); end
        endcase
      end
      S_SQ: begin
        mul_a = signed'({4'b0, mag_r[cnt_r[1:0]][29:0]});
        mul_b = signed'({1'b0, mag_r[cnt_r[1:0]][29:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign mx01   = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
  assign mx     = (mx01 > mag_r[2]) ? mx01 : mag_r[2];
  assign sq_sum = res_r + bit_r;
  assign q_nxt  = (num_r >= den_r) ? (q_r | (15'd1 << cnt_r[3:0])) : q_r;
  assign qv     = ({1'b0, q_nxt} > 16'(UNIT_Q14)) ? 16'(UNIT_Q14) : {1'b0, q_nxt};
  assign qs     = neg_r[csel_r] ? signed'(16'd0 - qv) : signed'(qv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= 2'd0;
      cnt_r   <= '0;
      csel_r  <= '0;
      vsel_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            if (phase_r != 2'd2) begin
              // hold vertex 0 or 1
              hp_r[phase_r[0] ? 3'd3 : 3'd0] <= in_ch.data.pos_x;
              hp_r[phase_r[0] ? 3'd4 : 3'd1] <= in_ch.data.pos_y;
              hp_r[phase_r[0] ? 3'd5 : 3'd2] <= in_ch.data.pos_z;
              ht_r[{phase_r[0], 1'b0}]  <= in_ch.data.tex_u;
              ht_r[{phase_r[0], 1'b1}]  <= in_ch.data.tex_v;
              phase_r <= phase_r[0] ? 2'd2 : 2'd1;
            end else begin
              phase_r  <= 2'd0;
              e1_r[0]  <= 33'(hp_r[3]) - 33'(hp_r[0]);
              e1_r[1]  <= 33'(hp_r[4]) - 33'(hp_r[1]);
              e1_r[2]  <= 33'(hp_r[5]) - 33'(hp_r[2]);
              e2_r[0]  <= 33'(in_ch.data.pos_x) - 33'(hp_r[0]);
              e2_r[1]  <= 33'(in_ch.data.pos_y) - 33'(hp_r[1]);
              e2_r[2]  <= 33'(in_ch.data.pos_z) - 33'(hp_r[2]);
              du1_r    <= 17'(ht_r[2]) - 17'(ht_r[0]);
              dv1_r    <= 17'(ht_r[3]) - 17'(ht_r[1]);
              du2_r    <= 17'(in_ch.data.tex_u) - 17'(ht_r[0]);
              dv2_r    <= 17'(in_ch.data.tex_v) - 17'(ht_r[1]);
              degen_r  <= 1'b0;
              cnt_r    <= '0;
              state_r  <= S_DET;
            end
          end
        end
        S_DET: begin
          if (cnt_r[0] == 1'b0) begin
            acc_r <= 66'(prod);
            cnt_r <= 5'd1;
          end else begin
            acc_r   <= acc_r - 66'(prod);
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (acc_r == '0) begin
            degen_r <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              tq_r[i] <= '0;
              bq_r[i] <= '0;
            end
            cnt_r   <= '0;
            state_r <= S_OUT;
          end else begin
            flip_r  <= acc_r[65];
            vsel_r  <= 1'b0;
            cnt_r   <= '0;
            state_r <= S_COMP;
          end
        end
        S_COMP: begin
          if (cnt_r[0] == 1'b0) begin
            acc_r <= 66'(prod);
          end else begin
            comp_r[ci] <= 52'(acc_r - 66'(prod));
          end
          if (cnt_r == 5'd5) begin
            state_r <= S_ABS;
          end
          cnt_r <= cnt_r + 5'd1;
        end
        S_ABS: begin
          for (int i = 0; i < 3; i++) begin
            mag_r[i] <= comp_r[i][51] ? 51'(-comp_r[i]) : comp_r[i][50:0];
            neg_r[i] <= comp_r[i][51] ^ flip_r;
          end
          if (comp_r[0] == '0 && comp_r[1] == '0 && comp_r[2] == '0) begin
            // zero vector: both outputs go to zero
            degen_r <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              tq_r[i] <= '0;
              bq_r[i] <= '0;
            end
            cnt_r   <= '0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          // one bit a cycle until the largest magnitude sits in [2^29, 2^30)
          if (mx[50:30] != '0) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
          end else if (!mx[29]) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
          end else begin
            acc_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          acc_r <= acc_r + 66'(prod);
          if (cnt_r == 5'd2) begin
            state_r <= S_SQRT;
            cnt_r   <= '0;
            res_r   <= '0;
            bit_r   <= 64'd1 << 62;
            sqv_r   <= acc_r[63:0] + 64'(prod);
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_SQRT: begin
          if (sqv_r >= sq_sum) begin
            sqv_r <= sqv_r - sq_sum;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (cnt_r == 5'd31) begin
            csel_r  <= '0;
            state_r <= S_DIVI;
          end
          cnt_r <= cnt_r + 5'd1;
        end
        S_DIVI: begin
          if (cnt_r == 5'd0) begin
            n_r   <= res_r[31:0];
            cnt_r <= 5'd1;
          end else begin
            num_r   <= {1'b0, mag_r[csel_r][29:0], 14'd0} + 45'(n_r >> 1);
            den_r   <= {n_r[30:0], 14'd0};
            q_r     <= '0;
            cnt_r   <= 5'd14;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (num_r >= den_r) num_r <= num_r - den_r;
          q_r   <= q_nxt;
          den_r <= den_r >> 1;
          if (cnt_r[3:0] == 4'd0) begin
            if (vsel_r) bq_r[csel_r] <= qs;
            else        tq_r[csel_r] <= qs;
            if (csel_r == 2'd2) begin
              state_r <= S_NEXTV;
            end else begin
              csel_r  <= csel_r + 2'd1;
              cnt_r   <= 5'd1;
              state_r <= S_DIVI;
            end
          end else begin
            cnt_r <= cnt_r - 5'd1;
          end
        end
        S_NEXTV: begin
          cnt_r <= '0;
          if (vsel_r) begin
            state_r <= S_OUT;
          end else begin
            vsel_r  <= 1'b1;
            state_r <= S_COMP;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            if (cnt_r == 5'd2) begin
              cnt_r   <= '0;
              state_r <= S_IDLE;
            end else begin
              cnt_r <= cnt_r + 5'd1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data.tangent_x        = tq_r[0];
  assign out_ch.data.tangent_y        = tq_r[1];
  assign out_ch.data.tangent_z        = tq_r[2];
  assign out_ch.data.bitangent_x      = bq_r[0];
  assign out_ch.data.bitangent_y      = bq_r[1];
  assign out_ch.data.bitangent_z      = bq_r[2];
  assign out_ch.data.degenerate       = degen_r;
  assign out_ch.data.last_of_triangle = (cnt_r == 5'd2);

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for triangle_tangent_bitangent
// Streams triangles of vertices with random gaps, predicts the three basis
// results of each triangle in fixed point and compares each whole result struct.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tgb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tgb_vtx_if   vtx_ch();
  tgb_basis_if basis_ch();

  triangle_tangent_bitangent u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (vtx_ch.sink),
    .out_ch (basis_ch.source)
  );

  always #5 clk = ~clk;

  vtx_item_t   vertex_queue[$];
  basis_item_t basis_expected[$];
  int          errors = 0;
  int          cycle_count = 0;
  bit          stall_go = 1'b0;
  bit          rx_hold = 1'b0;

  // predictor state
  logic [1:0]         corner_count = 2'd0;
  logic signed [31:0] held_pos[6];
  logic signed [15:0] held_tex[4];

  function automatic void queue_vtx(input vtx_item_t v);
    vertex_queue.insert(vertex_queue.size(), v);
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Normalize to Q1.14; returns 0 for a zero vector.
  function automatic bit unit_vec(input longint c[3], input bit flip,
                                  output logic signed [15:0] q[3]);
    longint unsigned m[3], mx, len2, n, v;
    bit neg[3];
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = (c[i] < 0) != flip;
      m[i] = c[i] < 0 ? -c[i] : c[i];
      if (m[i] > mx) mx = m[i];
    end
    for (int i = 0; i < 3; i++) q[i] = '0;
    if (mx == 0) return 1'b0;
    while ((mx >> 30) != 0) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    len2 = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
    n = root64(len2);
    for (int i = 0; i < 3; i++) begin
      v = (m[i] * UNIT_Q14 + n / 2) / n;
      if (v > UNIT_Q14) v = UNIT_Q14;
      q[i] = neg[i] ? -16'(v) : 16'(v);
    end
    return 1'b1;
  endfunction

  task automatic predict_basis(input vtx_item_t vi);
    longint e1[3], e2[3], tv[3], bv[3], p2[3];
    longint du1, dv1, du2, dv2, det;
    logic signed [15:0] tq[3], bq[3];
    bit degen;
    basis_item_t r;
    if (corner_count == 2'd3) corner_count = 2'd0;
    if (corner_count < 2) begin
      held_pos[corner_count*3]     = vi.pos_x;
      held_pos[corner_count*3 + 1] = vi.pos_y;
      held_pos[corner_count*3 + 2] = vi.pos_z;
      held_tex[corner_count*2]     = vi.tex_u;
      held_tex[corner_count*2 + 1] = vi.tex_v;
      corner_count++;
      return;
    end
    corner_count = 2'd0;
    p2[0] = vi.pos_x; p2[1] = vi.pos_y; p2[2] = vi.pos_z;
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(held_pos[3+i]) - longint'(held_pos[i]);
      e2[i] = p2[i] - longint'(held_pos[i]);
    end
    du1 = longint'(held_tex[2]) - longint'(held_tex[0]);
    dv1 = longint'(held_tex[3]) - longint'(held_tex[1]);
    du2 = longint'(vi.tex_u) - longint'(held_tex[0]);
    dv2 = longint'(vi.tex_v) - longint'(held_tex[1]);
    det = du1*dv2 - du2*dv1;
    degen = (det == 0);
    for (int i = 0; i < 3; i++) begin
      tq[i] = '0;
      bq[i] = '0;
    end
    if (!degen) begin
      for (int i = 0; i < 3; i++) begin
        tv[i] = e1[i]*dv2 - e2[i]*dv1;
        bv[i] = e2[i]*du1 - e1[i]*du2;
      end
      if (!unit_vec(tv, det < 0, tq)) degen = 1'b1;
      else if (!unit_vec(bv, det < 0, bq)) degen = 1'b1;
    end
    if (degen) begin
      for (int i = 0; i < 3; i++) begin
        tq[i] = '0;
        bq[i] = '0;
      end
    end
    for (int k = 0; k < 3; k++) begin
      r.tangent_x = tq[0]; r.tangent_y = tq[1]; r.tangent_z = tq[2];
      r.bitangent_x = bq[0]; r.bitangent_y = bq[1]; r.bitangent_z = bq[2];
      r.degenerate = degen;
      r.last_of_triangle = (k == 2);
      basis_expected.insert(basis_expected.size(), r);
    end
  endtask

  function automatic vtx_item_t mk_vtx(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                       logic [15:0] u, logic [15:0] v);
    vtx_item_t t;
    t.pos_x = x; t.pos_y = y; t.pos_z = z; t.tex_u = u; t.tex_v = v;
    return t;
  endfunction

  function automatic logic [31:0] rnd_pos(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      default: return 32'($signed($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  function automatic logic [15:0] rnd_tex(int mode);
    if (mode == 0) return 16'($urandom());
    return 16'($signed($urandom_range(0, 8192)) - 4096);
  endfunction

  // driver
  int        send_gap = 0;
  vtx_item_t cur_vtx;
  logic      vtx_taken;
  always @(negedge clk) begin
    if (!rst_n) begin
      vtx_ch.valid <= 1'b0;
      vtx_ch.data  <= '0;
    end else if (vtx_ch.valid && !vtx_taken) begin
      // hold the request
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      vtx_ch.valid <= 1'b0;
    end else if (vertex_queue.size() > 0) begin
      cur_vtx = vertex_queue.pop_front();
      vtx_ch.data  <= cur_vtx;
      vtx_ch.valid <= 1'b1;
      send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    end else begin
      vtx_ch.valid <= 1'b0;
    end
  end

  // record each accepted request for the driver and the predictor
  always @(posedge clk) begin
    if (!rst_n) begin
      vtx_taken <= 1'b0;
    end else begin
      vtx_taken <= vtx_ch.valid && vtx_ch.ready;
      if (vtx_ch.valid && vtx_ch.ready) predict_basis(vtx_ch.data);
    end
  end

  // long receiver stall
  initial begin
    wait (stall_go);
    @(negedge clk);
    rx_hold <= 1'b1;
    repeat (600) @(negedge clk);
    rx_hold <= 1'b0;
  end

  // receiver
  int recv_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      basis_ch.ready <= 1'b0;
    end else if (rx_hold) begin
      basis_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      basis_ch.ready <= 1'b0;
    end else begin
      basis_ch.ready <= 1'b1;
      recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    end
  end

  // monitor
  basis_item_t want;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && basis_ch.valid && basis_ch.ready) begin
      if (basis_expected.size() == 0) begin
        $display("%0t: unexpected result %h", $time, basis_ch.data);
        errors <= errors + 1;
      end else begin
        want = basis_expected.pop_front();
        if (basis_ch.data !== want) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, basis_ch.data);
          errors <= errors + 1;
        end
      end
    end
    if (cycle_count > 1500000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int mode, tmode;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes, zero determinant, zero-length vector, negative det
    queue_vtx(mk_vtx(0, 0, 0, 16'h0, 16'h0));
    queue_vtx(mk_vtx(32'h0001_0000, 0, 0, 16'h1000, 16'h0));
    queue_vtx(mk_vtx(0, 32'h0001_0000, 0, 16'h0, 16'h1000));
    queue_vtx(mk_vtx(0, 0, 0, 16'h0, 16'h0));
    queue_vtx(mk_vtx(32'h0001_0000, 0, 0, 16'h0, 16'h1000));
    queue_vtx(mk_vtx(0, 32'h0001_0000, 0, 16'h1000, 16'h0));
    queue_vtx(mk_vtx(5, 5, 5, 16'h0010, 16'h0010));
    queue_vtx(mk_vtx(9, 9, 9, 16'h0020, 16'h0020));
    queue_vtx(mk_vtx(1, 2, 3, 16'h0030, 16'h0030));
    queue_vtx(mk_vtx(7, 7, 7, 16'h0, 16'h0));
    queue_vtx(mk_vtx(7, 7, 7, 16'h1000, 16'h0));
    queue_vtx(mk_vtx(7, 7, 7, 16'h0, 16'h1000));
    queue_vtx(mk_vtx(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     16'h8000, 16'h7FFF));
    queue_vtx(mk_vtx(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     16'h7FFF, 16'h7FFF));
    queue_vtx(mk_vtx(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     16'h8000, 16'h8000));
    queue_vtx(mk_vtx(32'hFFFF_FFFF, 0, 32'h0000_0001, 16'hFFFF, 16'h0));
    queue_vtx(mk_vtx(0, 32'hFFFF_FFFF, 0, 16'h0, 16'hFFFF));
    queue_vtx(mk_vtx(32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF,
                     16'h0001, 16'h0001));
    // random triangles
    for (int t = 0; t < 62; t++) begin
      mode = $urandom_range(0, 2);
      tmode = $urandom_range(0, 3);
      if (t == 20) begin
        // stall the receiver while the sender keeps offering
        wait (vertex_queue.size() == 0);
        stall_go = 1'b1;
      end
      for (int k = 0; k < 3; k++)
        queue_vtx(mk_vtx(rnd_pos(mode), rnd_pos(mode), rnd_pos(mode),
                         rnd_tex(tmode == 0 ? 0 : 1),
                         rnd_tex(tmode == 0 ? 0 : 1)));
    end
    wait (vertex_queue.size() == 0 && !vtx_ch.valid);
    wait (basis_expected.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && basis_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
